// ----- rtl/core/polynomial_sign_comparator_macros.svh -----
// ----------------------------------------------------------------------------
// Polynomial sign comparator assertion macros
// Shared property forms for the checker of the comparator ports.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_SIGN_COMPARATOR_MACROS_SVH
`define POLYNOMIAL_SIGN_COMPARATOR_MACROS_SVH

// same-cycle implication, inactive while reset is high
`define PSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psc: same-cycle property failed");

// next-cycle implication, inactive while reset is high
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psc: next-cycle property failed");

// next-cycle implication that also holds across reset
`define PSC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("psc: reset property failed");

`endif

// ----- rtl/core/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// Polynomial sign comparator package
// Microcode control word, step program and coefficient table.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

   // width of the depth register
   localparam int DEPTH_W = 3;
   // width of an index into the coefficient table
   localparam int COEF_IDX_W = 4;

   typedef logic [3:0] step_type;

   // multiplier phase
   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LO,
      MUL_HI
   } mul_type;

   // first multiplier operand
   typedef enum logic {
      OPA_X,
      OPA_P
   } opa_type;

   // second multiplier operand
   typedef enum logic {
      OPB_X,
      OPB_T
   } opb_type;

   // register update performed by a step
   typedef enum logic [2:0] {
      ACT_NOP,
      ACT_SCALE,
      ACT_DIFF,
      ACT_TSET,
      ACT_PACC,
      ACT_XSET,
      ACT_OUT
   } act_type;

   // jump condition
   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_DEPTH_ZERO,
      JMP_K_MORE,
      JMP_I_MORE
   } cond_type;

   typedef struct packed {
      mul_type  mul;
      opa_type  opa;
      opb_type  opb;
      act_type  act;
      cond_type cond;
      step_type target;
   } ucode_type;

   // program step addresses
   localparam step_type STEP_SCALE = 4'd0;
   localparam step_type STEP_DIFF  = 4'd1;
   localparam step_type STEP_SQ_LO = 4'd2;
   localparam step_type STEP_SQ_HI = 4'd3;
   localparam step_type STEP_TSET  = 4'd4;
   localparam step_type STEP_PT_LO = 4'd5;
   localparam step_type STEP_PT_HI = 4'd6;
   localparam step_type STEP_PACC  = 4'd7;
   localparam step_type STEP_XP_LO = 4'd8;
   localparam step_type STEP_XP_HI = 4'd9;
   localparam step_type STEP_XSET  = 4'd10;
   localparam step_type STEP_OUT   = 4'd11;

   // control store
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type cw;
      unique case (step)
         STEP_SCALE: cw = '{MUL_NONE, OPA_X, OPB_X, ACT_SCALE, JMP_NONE,       STEP_SCALE};
         STEP_DIFF:  cw = '{MUL_NONE, OPA_X, OPB_X, ACT_DIFF,  JMP_DEPTH_ZERO, STEP_OUT};
         STEP_SQ_LO: cw = '{MUL_LO,   OPA_X, OPB_X, ACT_NOP,   JMP_NONE,       STEP_SCALE};
         STEP_SQ_HI: cw = '{MUL_HI,   OPA_X, OPB_X, ACT_NOP,   JMP_NONE,       STEP_SCALE};
         STEP_TSET:  cw = '{MUL_NONE, OPA_X, OPB_X, ACT_TSET,  JMP_NONE,       STEP_SCALE};
         STEP_PT_LO: cw = '{MUL_LO,   OPA_P, OPB_T, ACT_NOP,   JMP_NONE,       STEP_SCALE};
         STEP_PT_HI: cw = '{MUL_HI,   OPA_P, OPB_T, ACT_NOP,   JMP_NONE,       STEP_SCALE};
         STEP_PACC:  cw = '{MUL_NONE, OPA_X, OPB_X, ACT_PACC,  JMP_K_MORE,     STEP_PT_LO};
         STEP_XP_LO: cw = '{MUL_LO,   OPA_P, OPB_X, ACT_NOP,   JMP_NONE,       STEP_SCALE};
         STEP_XP_HI: cw = '{MUL_HI,   OPA_P, OPB_X, ACT_NOP,   JMP_NONE,       STEP_SCALE};
         STEP_XSET:  cw = '{MUL_NONE, OPA_X, OPB_X, ACT_XSET,  JMP_I_MORE,     STEP_SQ_LO};
         STEP_OUT:   cw = '{MUL_NONE, OPA_X, OPB_X, ACT_OUT,   JMP_NONE,       STEP_SCALE};
         default:    cw = '{MUL_NONE, OPA_X, OPB_X, ACT_NOP,   JMP_NONE,       STEP_OUT};
      endcase
      return cw;
   endfunction

   // central binomial coefficients over 4^k, in Q.15
   function automatic logic [15:0] coef_q15(input logic [COEF_IDX_W-1:0] idx);
      logic [15:0] c;
      case (idx)
         4'd0:    c = 16'd32768;
         4'd1:    c = 16'd16384;
         4'd2:    c = 16'd12288;
         4'd3:    c = 16'd10240;
         4'd4:    c = 16'd8960;
         4'd5:    c = 16'd8064;
         4'd6:    c = 16'd7392;
         4'd7:    c = 16'd6864;
         4'd8:    c = 16'd6435;
         default: c = 16'd0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/polynomial_sign_comparator.sv -----
// ----------------------------------------------------------------------------
// Polynomial sign comparator
// Scores a > b for two Q16.16 operands by composed odd sign polynomials.
// ----------------------------------------------------------------------------
// Usage
//   req channel: a_value and b_value, transferred when req_valid and
//   req_ready are both high. req_ready is high only while the block is idle.
//   rsp channel: greater_score in Q0.16 (65536 = a greater, 32768 = equal),
//   transferred when rsp_valid and rsp_ready are both high.
//   csr port: csr_wr_en writes csr_wr_data into the depth register at once;
//   write only while no item is in flight.
// Sequencing, with d = min(depth, MAX_DEPTH) stages
//   the result is loaded when the step program for d stages ends; the next
//   request is taken only after the block is back in idle, so one item is
//   finished before the next is taken. All products go through the single
//   shared multiplier: each product is built from the low and then the high
//   half of the second operand, and the step program walks Horner's
//   rule one product at a time.
// Reset: synchronous, clears the sequencer and the output valid, and sets
//   depth to 3.
// Receiver stall: the finished score waits in the output register while a
//   new request is taken; a second finished score waits in the last program
//   step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_sign_comparator #(
   parameter int MAX_DEPTH = 4,
   parameter int FRAC_BITS = 30
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [31:0]                  req_a_value,
   input  wire logic [31:0]                  req_b_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [16:0]                       rsp_greater_score,
   input  wire logic                         csr_wr_en,
   input  wire logic [psc_pkg::DEPTH_W-1:0]  csr_wr_data
);

   import psc_pkg::*;

   // datapath widths
   localparam int W   = FRAC_BITS + 2;            // x, p and operand magnitudes
   localparam int TW  = FRAC_BITS + 1;            // t in [0, 1]
   localparam int H   = (W + 1) / 2;              // low half of second operand
   localparam int PW  = W + H;                    // partial product
   localparam int AW  = 2 * W;                    // full product
   localparam int QW  = AW - FRAC_BITS;           // product at operand scale
   localparam int SW  = FRAC_BITS + 16;           // aligned operand
   localparam int IW  = $clog2(MAX_DEPTH + 1);    // stage and Horner counters
   localparam int DW  = (IW > DEPTH_W) ? IW : DEPTH_W;
   localparam int CSH = FRAC_BITS - 15;           // coefficient alignment
   localparam int OSH = FRAC_BITS - 15;           // output alignment
   localparam int OW  = W + 1 - OSH;              // aligned output width

   localparam logic [W-1:0] ONE_Q = W'(1) << FRAC_BITS;
   localparam logic [W:0]   RND_Q = (W + 1)'(1) << (FRAC_BITS - 16);
   localparam logic [16:0]  SCORE_MAX = 17'd65536;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type          state_ff, state_in;
   step_type           step_ff, step_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [16:0]        score_ff, score_in;
   logic [31:0]        a_ff, a_in;
   logic [31:0]        b_ff, b_in;
   logic [4:0]         s_ff, s_in;
   logic [W-1:0]       x_ff, x_in;
   logic [TW-1:0]      t_ff, t_in;
   logic [W-1:0]       p_ff, p_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic [IW-1:0]      k_ff, k_in;
   logic [IW-1:0]      i_ff, i_in;

   ucode_type          cw;
   logic [DW-1:0]      depth_eff;
   logic [W-1:0]       x_mag;
   logic [W-1:0]       op_a;
   logic [W-1:0]       op_b;
   logic [H-1:0]       op_b_half;
   logic [PW-1:0]      prod;
   logic [QW-1:0]      q;
   logic [W-1:0]       q_clamp;
   logic [31:0]        max_ab;
   logic [31:0]        max_m1;
   logic [4:0]         s_calc;
   logic [SW-1:0]      a_sh;
   logic [SW-1:0]      b_sh;
   logic [W-1:0]       sum_q;
   logic [W:0]         rnd_q;
   logic [OW-1:0]      score_full;
   logic [15:0]        coef_i;
   logic [15:0]        coef_k;
   logic               can_load;
   logic               jump;

   // control word of the current step
   assign cw = ucode_rom(step_ff);

   // effective depth, saturated to the number of built stages
   assign depth_eff = (DW'(depth_ff) > DW'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : DW'(depth_ff);

   // shared multiplier, one half of the second operand per cycle
   assign x_mag     = x_ff[W-1] ? (~x_ff + W'(1)) : x_ff;
   assign op_a      = (cw.opa == OPA_P) ? p_ff : x_mag;
   assign op_b      = (cw.opb == OPB_T) ? W'(t_ff) : x_mag;
   assign op_b_half = (cw.mul == MUL_HI) ? H'(op_b[W-1:H]) : op_b[H-1:0];
   assign prod      = PW'(op_a) * PW'(op_b_half);

   // product brought back to operand scale, truncated
   assign q       = acc_ff[AW-1:FRAC_BITS];
   assign q_clamp = (q > QW'(ONE_Q)) ? ONE_Q : q[W-1:0];

   // coefficients for the top of Horner's rule and for the running term
   assign coef_i = coef_q15(COEF_IDX_W'(i_ff));
   assign coef_k = coef_q15(COEF_IDX_W'(k_ff - IW'(1)));

   // smallest common shift that brings the larger operand to at most 1.0
   assign max_ab = (a_ff > b_ff) ? a_ff : b_ff;
   assign max_m1 = max_ab - 32'd1;

   always_comb begin
      s_calc = '0;
      if (max_ab > 32'd65536) begin
         for (int n = 0; n < 16; n++) begin
            if (max_m1[16 + n]) begin
               s_calc = 5'(n + 1);
            end
         end
      end
   end

   // operands aligned to the fraction width and scaled down
   assign a_sh = {a_ff, {(FRAC_BITS - 16){1'b0}}} >> s_ff;
   assign b_sh = {b_ff, {(FRAC_BITS - 16){1'b0}}} >> s_ff;

   // output rounding: (x + 1) / 2 in Q0.16, half up
   assign sum_q      = x_ff + ONE_Q;
   assign rnd_q      = (W + 1)'(sum_q) + RND_Q;
   assign score_full = rnd_q[W:OSH];

   assign can_load = !rsp_valid_ff || rsp_ready;

   // jump condition of the current step
   always_comb begin
      case (cw.cond)
         JMP_DEPTH_ZERO: jump = (depth_eff == '0);
         JMP_K_MORE:     jump = (k_ff != IW'(1));
         JMP_I_MORE:     jump = (DW'(i_ff) < depth_eff);
         default:        jump = 1'b0;
      endcase
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff;
      score_in     = score_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      s_in         = s_ff;
      x_in         = x_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      i_in         = i_ff;

      // configuration write
      if (csr_wr_en) begin
         depth_in = csr_wr_data;
      end

      // result transfer frees the output register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in     = req_a_value;
               b_in     = req_b_value;
               step_in  = STEP_SCALE;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // multiplier accumulate
            case (cw.mul)
               MUL_LO:  acc_in = AW'(prod);
               MUL_HI:  acc_in = acc_ff + (AW'(prod) << H);
               default: acc_in = acc_ff;
            endcase

            // register updates
            unique case (cw.act)
               ACT_SCALE: s_in = s_calc;
               ACT_DIFF: begin
                  x_in = a_sh[W-1:0] - b_sh[W-1:0];
                  i_in = IW'(1);
               end
               ACT_TSET: begin
                  t_in = (q >= QW'(ONE_Q)) ? '0 : TW'(ONE_Q - q[W-1:0]);
                  p_in = W'({coef_i, {CSH{1'b0}}});
                  k_in = i_ff;
               end
               ACT_PACC: begin
                  p_in = W'({coef_k, {CSH{1'b0}}}) + q[W-1:0];
                  k_in = k_ff - IW'(1);
               end
               ACT_XSET: begin
                  x_in = x_ff[W-1] ? (~q_clamp + W'(1)) : q_clamp;
                  if (jump) begin
                     i_in = i_ff + IW'(1);
                  end
               end
               ACT_OUT: begin
                  if (can_load) begin
                     score_in     = (score_full > OW'(SCORE_MAX)) ? SCORE_MAX
                                                                  : score_full[16:0];
                     rsp_valid_in = 1'b1;
                  end
               end
               default: ;
            endcase

            // step counter
            if (cw.act == ACT_OUT) begin
               if (can_load) begin
                  state_in = ST_IDLE;
               end
            end else if (jump) begin
               step_in = cw.target;
            end else begin
               step_in = step_ff + step_type'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_SCALE;
         depth_ff     <= DEPTH_W'(3);
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         i_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
      end
      score_ff <= score_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      s_ff     <= s_in;
      x_ff     <= x_in;
      t_ff     <= t_in;
      p_ff     <= p_in;
      acc_ff   <= acc_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_greater_score = score_ff;

endmodule

`default_nettype wire

// ----- rtl/core/psc_checker.sv -----
// ----------------------------------------------------------------------------
// Polynomial sign comparator checker
// Port-level properties of the comparator, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polynomial_sign_comparator_macros.svh"

module psc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [16:0] rsp_greater_score
);

   // a stalled result stays offered
   `PSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // score never exceeds 1.0
   `PSC_ASSERT_SAME(a_score_range, clock, reset, rsp_valid, rsp_greater_score <= 17'd65536)

   // one item at a time: no request is taken right after a transfer
   `PSC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // reset leaves no result behind
   `PSC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule

bind polynomial_sign_comparator psc_checker u_psc_checker (.*);

`default_nettype wire
